// ===== sv/tksel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types and constants of the top-k score selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

    localparam int SCORE_W  = 16;
    localparam int OUT_CH_W = 6;
    localparam int RANK_W   = 3;
    localparam int CNT_W    = 4;
    // ranked list never holds more than this many entries
    localparam int LIST_CAP = 8;

    typedef struct packed {
        logic step;      // input beat accepted
        logic load_out;  // load the next ranked entry into the output register
        logic end_set;   // last entry loaded, clear for the next set
    } cmd_t;

    typedef struct packed {
        logic emit_last; // entry at the current rank is the final one
    } status_t;

    typedef struct packed {
        logic [OUT_CH_W-1:0] channel;
        logic [SCORE_W-1:0]  rank_score;
        logic [RANK_W-1:0]   rank;
        logic [CNT_W-1:0]    sel_total;
        logic                is_last;
        logic                overflow;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/tksel_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksel_in_if
// Score channel: one score per beat, with the end-of-set mark.
// ----------------------------------------------------------------------------
interface tksel_in_if;
    import tksel_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               final_channel;

    modport source (output valid, output score, output final_channel, input ready);
    modport sink (input valid, input score, input final_channel, output ready);

endinterface
`default_nettype wire

// ===== sv/tksel_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksel_out_if
// Ranked result channel: one list entry per beat.
// ----------------------------------------------------------------------------
interface tksel_out_if;
    import tksel_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_CH_W-1:0] channel;
    logic [SCORE_W-1:0]  rank_score;
    logic [RANK_W-1:0]   rank;
    logic [CNT_W-1:0]    sel_total;
    logic                is_last;
    logic                overflow;

    modport source (output valid, output channel, output rank_score, output rank,
                    output sel_total, output is_last, output overflow,
                    input ready);
    modport sink (input valid, input channel, input rank_score, input rank,
                  input sel_total, input is_last, input overflow,
                  output ready);

endinterface
`default_nettype wire

// ===== sv/top_k_score_selector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_score_selector_core
// Keeps the highest scores of a set of channels in a ranked list and sends
// the list out rank by rank at the end of each set.
// ----------------------------------------------------------------------------
//  port            dir   beat contents
//  item            in    score, final_channel (channel index counted here)
//  result          out   channel, rank_score, rank, sel_total, is_last,
//                        overflow
//  cfg_we/wdata    in    max_selected limit, no read-back
//
//  one score beat per cycle while collecting; the insert is a single pass
//  through the compare-and-shift cell row.
//  after the final beat of a set, one result beat per cycle for each kept
//  entry (one beat for an empty list), limited by the output register;
//  no score beat is taken during that time.
//  result stalls hold the emit walk; the next set starts once the last
//  result beat sits in the output register.
//  reset clears the list count, channel counter and overflow flag and sets
//  the limit to eight entries.
// ----------------------------------------------------------------------------
module top_k_score_selector_core
    import tksel_pkg::*;
#(
    parameter int MAX_SELECTED = 8,
    parameter int MAX_CHANNELS = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    tksel_in_if.sink              item,
    tksel_out_if.source           result
);

    cmd_t    cmd;
    status_t status;
    result_t res;
    logic    in_ready;
    logic    out_valid;

    tksel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_final  (item.final_channel),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    tksel_datapath #(
        .MAX_SELECTED (MAX_SELECTED),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .score     (item.score),
        .cmd       (cmd),
        .status    (status),
        .result    (res)
    );

    assign item.ready        = in_ready;
    assign result.valid      = out_valid;
    assign result.channel    = res.channel;
    assign result.rank_score = res.rank_score;
    assign result.rank       = res.rank;
    assign result.sel_total  = res.sel_total;
    assign result.is_last    = res.is_last;
    assign result.overflow   = res.overflow;

endmodule
`default_nettype wire

// ===== sv/tksel_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksel_ctrl
// Controller: accepts scores, then walks the emit phase one beat per rank.
// ----------------------------------------------------------------------------
module tksel_ctrl
    import tksel_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_final,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t status
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        cmd.end_set  = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (in_final)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.end_set = 1'b1;
                        state_next  = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tksel_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksel_datapath
// Row of compare-and-shift cells holding the ranked list, channel counter,
// limit register and the output register.
// ----------------------------------------------------------------------------
module tksel_datapath
    import tksel_pkg::*;
#(
    parameter int MAX_SELECTED = 8,
    parameter int MAX_CHANNELS = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CNT_W-1:0]   cfg_wdata,
    input  wire logic [SCORE_W-1:0] score,
    input  wire cmd_t               cmd,
    output status_t                 status,
    output result_t                 result
);

    localparam int LIST_DEPTH = (MAX_SELECTED < LIST_CAP) ? MAX_SELECTED : LIST_CAP;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CH_W       = $clog2(MAX_CHANNELS);
    localparam int NCH_W      = $clog2(MAX_CHANNELS + 1);

    logic [CNT_W-1:0]   max_sel_reg;
    logic [SCORE_W-1:0] score_reg [LIST_DEPTH];
    logic [CH_W-1:0]    ch_reg    [LIST_DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NCH_W-1:0]   next_ch_reg;
    logic               overflow_reg;
    logic [IDX_W-1:0]   rank_reg;
    result_t            result_reg;

    logic [CNT_W-1:0]      k;
    logic [CNT_W-1:0]      cnt;
    logic [LIST_DEPTH-1:0] keep_ahead;
    logic                  free_slot;
    logic                  ch_full;
    logic                  do_insert;
    logic [SCORE_W-1:0]    cell_score [LIST_DEPTH];
    logic [CH_W-1:0]       cell_ch    [LIST_DEPTH];

    assign k   = (max_sel_reg > CNT_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : max_sel_reg;
    assign cnt = (count_reg > k) ? k : count_reg;

    assign ch_full   = (next_ch_reg >= NCH_W'(MAX_CHANNELS));
    assign do_insert = cmd.step && !ch_full && (score != '0);

    // entries that stay ahead of the new score (ties keep the earlier channel)
    always_comb
    begin
        free_slot = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            keep_ahead[i] = (CNT_W'(i) < cnt) && (score_reg[i] >= score);
            if ((CNT_W'(i) < k) && !keep_ahead[i])
            begin
                free_slot = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = cnt;
        if (free_slot && (cnt < k))
        begin
            count_next = cnt + CNT_W'(1);
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            always_comb
            begin
                if (keep_ahead[g])
                begin
                    cell_score[g] = score_reg[g];
                    cell_ch[g]    = ch_reg[g];
                end
                else
                begin
                    cell_score[g] = score;
                    cell_ch[g]    = next_ch_reg[CH_W-1:0];
                end
            end
        end
        else
        begin : g_body
            always_comb
            begin
                if (keep_ahead[g])
                begin
                    cell_score[g] = score_reg[g];
                    cell_ch[g]    = ch_reg[g];
                end
                else if (keep_ahead[g-1])
                begin
                    cell_score[g] = score;
                    cell_ch[g]    = next_ch_reg[CH_W-1:0];
                end
                else
                begin
                    cell_score[g] = score_reg[g-1];
                    cell_ch[g]    = ch_reg[g-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (do_insert)
            begin
                score_reg[g] <= cell_score[g];
                ch_reg[g]    <= cell_ch[g];
            end
        end
    end

    // emit side
    logic [CNT_W-1:0] rank_ext;
    assign rank_ext         = CNT_W'(rank_reg);
    assign status.emit_last = (cnt == '0) || ((rank_ext + CNT_W'(1)) == cnt);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.rank      <= RANK_W'(rank_reg);
            result_reg.sel_total <= cnt;
            result_reg.is_last   <= status.emit_last;
            result_reg.overflow  <= overflow_reg;
            if (cnt == '0)
            begin
                result_reg.channel    <= '0;
                result_reg.rank_score <= '0;
            end
            else
            begin
                result_reg.channel    <= OUT_CH_W'(ch_reg[rank_reg]);
                result_reg.rank_score <= score_reg[rank_reg];
            end
        end
    end

    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sel_reg  <= CNT_W'(LIST_CAP);
            count_reg    <= '0;
            next_ch_reg  <= '0;
            overflow_reg <= 1'b0;
            rank_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_sel_reg <= cfg_wdata;
            end
            if (cmd.end_set)
            begin
                count_reg    <= '0;
                next_ch_reg  <= '0;
                overflow_reg <= 1'b0;
                rank_reg     <= '0;
            end
            else
            begin
                if (cmd.load_out)
                begin
                    rank_reg <= rank_reg + IDX_W'(1);
                end
                if (cmd.step)
                begin
                    if (ch_full)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    else
                    begin
                        next_ch_reg <= next_ch_reg + NCH_W'(1);
                        if (do_insert)
                        begin
                            count_reg <= count_next;
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire
